// ----- hdl/spfp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spfp_pkg
// Shared types and codes for the reply frame parser.
// ---------------------------------------------------------------------------
package spfp_pkg;

    localparam logic [7:0] MARK_START = 8'hE0;
    localparam logic [7:0] MARK_ERROR = 8'hEF;
    localparam logic [7:0] REPLY_BIT  = 8'h80;

    localparam int CMD_W   = 7;
    localparam int CFG_W   = 8;
    localparam int LEN_W   = 15;

    // register indexes
    localparam logic REG_EXPECTED_COMMAND = 1'b0;
    localparam logic REG_MAX_PARAMS       = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_LEN  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // error codes
    localparam logic [LEN_W-1:0] ERR_BAD_START = 15'd0;
    localparam logic [LEN_W-1:0] ERR_BAD_ECHO  = 15'd1;

    // parser phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ECHO  = 3'd1;
    localparam logic [2:0] PH_COUNT = 3'd2;
    localparam logic [2:0] PH_LEN1  = 3'd3;
    localparam logic [2:0] PH_LEN2  = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CLOSE = 3'd6;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       param_index;
        logic [LEN_W-1:0] value;
        logic             error_marker_seen;
        logic             last;
    } out_word_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } result_t;

endpackage

// ----- hdl/spfp_parser.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spfp_parser
// Frame state, configuration registers and the per-byte parse step.
// ---------------------------------------------------------------------------
module spfp_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  spfp_pkg::in_word_t        in_word,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [spfp_pkg::CFG_W-1:0] cfg_data,
    output spfp_pkg::result_t         result
);
    import spfp_pkg::*;

    logic [CMD_W-1:0] expected_command_reg;
    logic [7:0]       max_params_reg;

    logic [2:0]       phase_reg,         phase_next;
    logic [7:0]       params_total_reg,  params_total_next;
    logic [7:0]       current_param_reg, current_param_next;
    logic [LEN_W-1:0] bytes_left_reg,    bytes_left_next;
    logic [6:0]       length_high_reg,   length_high_next;
    logic             err_flag_reg,      err_flag_next;

    logic [7:0]       b;
    logic [7:0]       param_inc;
    logic [2:0]       after_param;
    logic [LEN_W-1:0] long_len;
    logic [LEN_W-1:0] bytes_dec;

    assign b           = in_word.rx_byte;
    assign param_inc   = current_param_reg + 8'd1;
    assign after_param = (param_inc >= params_total_reg) ? PH_CLOSE : PH_LEN1;
    assign long_len    = {length_high_reg, b};
    assign bytes_dec   = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        params_total_next  = params_total_reg;
        current_param_next = current_param_reg;
        bytes_left_next    = bytes_left_reg;
        length_high_next   = length_high_reg;
        err_flag_next      = err_flag_reg;
        result.valid                  = 1'b0;
        result.word.kind              = KIND_LEN;
        result.word.param_index       = current_param_reg;
        result.word.value             = '0;
        result.word.error_marker_seen = err_flag_reg;
        result.word.last              = 1'b0;

        if (in_word.frame_start)
        begin
            if (b == MARK_START || b == MARK_ERROR)
            begin
                err_flag_next = (b == MARK_ERROR);
                phase_next    = PH_ECHO;
            end
            else
            begin
                err_flag_next                 = 1'b0;
                phase_next                    = PH_IDLE;
                result.valid                  = 1'b1;
                result.word.kind              = KIND_ERR;
                result.word.param_index       = '0;
                result.word.value             = ERR_BAD_START;
                result.word.error_marker_seen = 1'b0;
                result.word.last              = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_ECHO:
                begin
                    if (b == ({1'b0, expected_command_reg} | REPLY_BIT))
                        phase_next = PH_COUNT;
                    else
                    begin
                        phase_next              = PH_IDLE;
                        result.valid            = 1'b1;
                        result.word.kind        = KIND_ERR;
                        result.word.param_index = '0;
                        result.word.value       = ERR_BAD_ECHO;
                        result.word.last        = 1'b1;
                    end
                end
                PH_COUNT:
                begin
                    params_total_next  = (b > max_params_reg) ? max_params_reg : b;
                    current_param_next = '0;
                    phase_next = (params_total_next == '0) ? PH_CLOSE : PH_LEN1;
                end
                PH_LEN1:
                begin
                    if (b[7])
                    begin
                        length_high_next = b[6:0];
                        phase_next       = PH_LEN2;
                    end
                    else
                    begin
                        result.valid      = 1'b1;
                        result.word.kind  = KIND_LEN;
                        result.word.value = {7'd0, b};
                        bytes_left_next   = {7'd0, b};
                        if (b == '0)
                        begin
                            current_param_next = param_inc;
                            phase_next         = after_param;
                        end
                        else
                            phase_next = PH_DATA;
                    end
                end
                PH_LEN2:
                begin
                    result.valid      = 1'b1;
                    result.word.kind  = KIND_LEN;
                    result.word.value = long_len;
                    bytes_left_next   = long_len;
                    if (long_len == '0)
                    begin
                        current_param_next = param_inc;
                        phase_next         = after_param;
                    end
                    else
                        phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    result.valid      = 1'b1;
                    result.word.kind  = KIND_DATA;
                    result.word.value = {7'd0, b};
                    bytes_left_next   = bytes_dec;
                    if (bytes_dec == '0)
                    begin
                        current_param_next = param_inc;
                        phase_next         = after_param;
                    end
                end
                PH_CLOSE:
                begin
                    phase_next              = PH_IDLE;
                    result.valid            = 1'b1;
                    result.word.kind        = KIND_DONE;
                    result.word.param_index = '0;
                    result.word.value       = {7'd0, params_total_reg};
                    result.word.last        = 1'b1;
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end

        if (!step)
        begin
            phase_next         = phase_reg;
            params_total_next  = params_total_reg;
            current_param_next = current_param_reg;
            bytes_left_next    = bytes_left_reg;
            length_high_next   = length_high_reg;
            err_flag_next      = err_flag_reg;
            result.valid       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_command_reg <= '0;
            max_params_reg       <= 8'd1;
            phase_reg            <= PH_IDLE;
            params_total_reg     <= '0;
            current_param_reg    <= '0;
            bytes_left_reg       <= '0;
            length_high_reg      <= '0;
            err_flag_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == REG_EXPECTED_COMMAND)
                expected_command_reg <= cfg_data[CMD_W-1:0];
            if (cfg_write && cfg_index == REG_MAX_PARAMS)
                max_params_reg <= cfg_data;
            phase_reg         <= phase_next;
            params_total_reg  <= params_total_next;
            current_param_reg <= current_param_next;
            bytes_left_reg    <= bytes_left_next;
            length_high_reg   <= length_high_next;
            err_flag_reg      <= err_flag_next;
        end
    end

    // data phase always holds a nonzero byte count
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("data phase with zero byte count");

    // terminal results always flagged last
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.word.kind == KIND_DONE || result.word.kind == KIND_ERR)
        |-> result.word.last)
        else $error("terminal word without last");

    // a terminal result returns the parser to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.word.last |=> phase_reg == PH_IDLE)
        else $error("parser not idle after terminal word");

endmodule

// ----- hdl/spfp_out_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spfp_out_queue
// Two-entry result buffer; decouples the parser from output stall.
// ---------------------------------------------------------------------------
module spfp_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  spfp_pkg::result_t   push,
    output logic                has_space,
    output logic                out_valid,
    input  logic                out_stall,
    output spfp_pkg::out_word_t out_data
);
    import spfp_pkg::*;

    out_word_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign has_space = (count_reg != 2'd2);
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + 2'd1;
        else if (!push.valid && pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && !has_space))
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |=> out_valid)
        else $error("pushed word not visible");

endmodule

// ----- hdl/spi_response_frame_parser_top.sv -----
`timescale 1ns / 1ps
// An accepted word is held in the input register; its result (if any) goes through the output queue to out_data.
// Throughput: one word per cycle while the queue has space; the parse step is a single registered pass.
// Input is held in one register; a two-entry output queue absorbs output stall.
// Reset (rst_n low, async): parser idle, expected_command 0, max_params 1, queue empty.
// ---------------------------------------------------------------------------
// spi_response_frame_parser_top
// Byte-wise reply frame parser: input register, parse step, output queue.
// ---------------------------------------------------------------------------
module spi_response_frame_parser_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  spfp_pkg::in_word_t         in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output spfp_pkg::out_word_t        out_data,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [spfp_pkg::CFG_W-1:0] cfg_data
);
    import spfp_pkg::*;

    in_word_t in_word_reg;
    logic     in_full_reg, in_full_next;
    logic     advance;
    logic     has_space;
    logic     in_take;
    result_t  result;

    assign advance  = in_full_reg && has_space;
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_take || (in_full_reg && !advance);
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_word_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else
            in_full_reg <= in_full_next;
    end

    spfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .in_word   (in_word_reg),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    spfp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result),
        .has_space (has_space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_full_reg)
        else $error("accepted word not held");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !advance |=> in_full_reg && $stable(in_word_reg))
        else $error("held word lost or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> advance)
        else $error("result without parse step");

endmodule
